[hw/rtl/urde_pkg.sv]
// Shared constants, types and the digit character table for the radix digit emitter.
// No dependencies; imported by every module of the block.
package urde_pkg;

    // Field widths fixed by the interface
    localparam int VALUE_W   = 64;
    localparam int RADIX_W   = 5;
    localparam int CNT_W     = 7;
    localparam int CHAR_W    = 8;

    // Build-time sizing
    localparam int VALUE_BITS    = 64;
    localparam int MAX_WIDTH     = 64;
    localparam int BITS_PER_STEP = 8;

    // Divider geometry: dividend padded to whole steps
    localparam int DIV_STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int QUO_W      = DIV_STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_STEPS - 1);
    localparam int REM_W      = RADIX_W - 1;

    // Digit buffer: base 2 gives the most digits
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int DIG_AW     = $clog2(MAX_DIGITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
    localparam logic [CNT_W-1:0]   WIDTH_SAT = CNT_W'(MAX_WIDTH);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] ERR_CHAR   = 8'h00;

    localparam logic [CHAR_W-1:0] DIGIT_ASCII [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic               start;
        logic [QUO_W-1:0]   dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
        logic [REM_W-1:0]   remainder;
    } div_rsp_t;

endpackage

[hw/rtl/urde_div_unit.sv]
// Iterative divider: dividend by a radix of 2..16, BITS_PER_STEP quotient bits per cycle.
// Depends on urde_pkg.
module urde_div_unit
    import urde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [QUO_W-1:0]      work_reg;
    logic [QUO_W-1:0]      work_next;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      rem_next;
    logic [RADIX_W-1:0]    divisor_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Restoring division, MSB first; quotient bits shift in at the bottom
    always_comb
    begin : step
        logic [RADIX_W-1:0] trial;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial = {rem_next, work_next[QUO_W-1]};
            if (trial >= divisor_reg)
            begin
                trial     = trial - divisor_reg;
                work_next = {work_next[QUO_W-2:0], 1'b1};
            end
            else
            begin
                work_next = {work_next[QUO_W-2:0], 1'b0};
            end
            rem_next = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = work_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hw/rtl/urde_digit_buf.sv]
// Digit buffer: one write port, one read port with registered read data.
// Depends on urde_pkg for depth and widths.
module urde_digit_buf
    import urde_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [DIG_AW-1:0] wr_addr,
    input  logic [REM_W-1:0]  wr_data,
    input  logic [DIG_AW-1:0] rd_addr,
    output logic [REM_W-1:0]  rd_data
);

    logic [REM_W-1:0] mem [MAX_DIGITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/unsigned_radix_digit_emitter.sv]
// Top level of the radix digit emitter: sequencer, shared divider, digit buffer.
// Depends on urde_pkg, urde_div_unit and urde_digit_buf.
//
//  channel | handshake            | payload                     | flow
//  --------+----------------------+-----------------------------+-------------------------
//  input   | start, busy          | value, radix, min_width     | beat taken: start & !busy
//  result  | strobe               | digit_char, last, error     | one beat per strobe cycle
//
// Sequence: each digit costs one pass of the shared divider, the divider retiring 8
// quotient bits per cycle. Then the characters go out one per cycle through the
// digit buffer read register and the output register. Busy stays high while an
// item runs; its last beat comes out in the cycle busy drops.
// A bad radix gives its error beat on the next cycle and busy stays low.
// Reset clears the sequencer and output strobe; the digit buffer needs no clear.
// The receiver cannot stall: result beats go out on their own schedule.
module unsigned_radix_digit_emitter
    import urde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    input  logic [RADIX_W-1:0] radix,
    input  logic [CNT_W-1:0]   min_width,
    output logic               strobe,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last,
    output logic               error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t             state_reg, state_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [CNT_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   ndig_reg, ndig_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_pad_reg, s1_pad_next;
    logic               s1_last_reg, s1_last_next;
    logic               strobe_reg, strobe_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               error_reg, error_next;

    logic               accept;
    logic               radix_ok;
    logic               err_beat;
    logic [CNT_W-1:0]   width_sat;
    logic [CNT_W-1:0]   ndig_inc;
    logic [CNT_W-1:0]   total;
    logic [QUO_W-1:0]   value_ext;
    logic               quo_zero;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               buf_wr_en;
    logic [REM_W-1:0]   buf_rd_data;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && (state_reg == S_IDLE);
    assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
    assign err_beat = accept && !radix_ok;

    assign width_sat = (min_width > WIDTH_SAT) ? WIDTH_SAT : min_width;
    assign value_ext = QUO_W'(value[VALUE_BITS-1:0]);
    assign quo_zero  = (div_rsp.quotient == '0);

    // Digit count including the one retiring now; padding raises it to the width
    assign ndig_inc = ndig_reg + 1'b1;
    assign total    = (ndig_inc > width_reg) ? ndig_inc : width_reg;

    // Divider is restarted on its own quotient until that reaches zero
    assign div_req.start    = (accept && radix_ok)
                           || ((state_reg == S_DIV) && div_rsp.done && !quo_zero);
    assign div_req.dividend = (state_reg == S_IDLE) ? value_ext : div_rsp.quotient;
    assign div_req.divisor  = (state_reg == S_IDLE) ? radix : radix_reg;

    // Remainders land least significant first at the running digit count
    assign buf_wr_en = (state_reg == S_DIV) && div_rsp.done;

    urde_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    urde_digit_buf u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (ndig_reg[DIG_AW-1:0]),
        .wr_data (div_rsp.remainder),
        .rd_addr (pos_reg[DIG_AW-1:0]),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        radix_next    = radix_reg;
        width_next    = width_reg;
        ndig_next     = ndig_reg;
        pos_next      = pos_reg;
        s1_valid_next = 1'b0;
        s1_pad_next   = s1_pad_reg;
        s1_last_next  = s1_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && radix_ok)
                begin
                    state_next = S_DIV;
                    radix_next = radix;
                    width_next = width_sat;
                    ndig_next  = '0;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    ndig_next = ndig_inc;
                    if (quo_zero)
                    begin
                        state_next = S_EMIT;
                        pos_next   = total - 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                // pos counts down from the leftmost character; at or above ndig it is a pad
                s1_valid_next = 1'b1;
                s1_pad_next   = (pos_reg >= ndig_reg);
                s1_last_next  = (pos_reg == '0);
                if (pos_reg == '0)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output stage: buffered digit beat or a bad-radix beat
        strobe_next = s1_valid_reg || err_beat;
        char_next   = char_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        if (s1_valid_reg)
        begin
            char_next  = s1_pad_reg ? ASCII_ZERO : DIGIT_ASCII[buf_rd_data];
            last_next  = s1_last_reg;
            error_next = 1'b0;
        end
        else if (err_beat)
        begin
            char_next  = ERR_CHAR;
            last_next  = 1'b1;
            error_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            radix_reg    <= '0;
            width_reg    <= '0;
            ndig_reg     <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_pad_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            strobe_reg   <= 1'b0;
            char_reg     <= '0;
            last_reg     <= 1'b0;
            error_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            radix_reg    <= radix_next;
            width_reg    <= width_next;
            ndig_reg     <= ndig_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
            s1_pad_reg   <= s1_pad_next;
            s1_last_reg  <= s1_last_next;
            strobe_reg   <= strobe_next;
            char_reg     <= char_next;
            last_reg     <= last_next;
            error_reg    <= error_next;
        end
    end

    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;
    assign error      = error_reg;

    // Error beat is always a lone final beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && error |-> last)
        else $error("error beat without last");

    // Divider only finishes while the sequencer waits on it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide phase");

    // Digit beats carry only valid lower-case digit characters
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !error |->
            ((digit_char >= 8'h30) && (digit_char <= 8'h39))
         || ((digit_char >= 8'h61) && (digit_char <= 8'h66)))
        else $error("digit beat outside character set");

    // A bad radix gives an error beat next cycle, and busy stays low
    a_bad_radix: assert property (@(posedge clk) disable iff (!rst_n)
        err_beat |=> strobe && error && !busy)
        else $error("bad radix did not give a lone error beat");

endmodule
